### rtl/timestamped_transport_delay_queue_top_assert.svh
// assertion macros for the transport delay queue
// uses the enclosing module's clk and active-low rst_n
`ifndef TIMESTAMPED_TRANSPORT_DELAY_QUEUE_TOP_ASSERT_SVH
`define TIMESTAMPED_TRANSPORT_DELAY_QUEUE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// property checked on every edge outside reset
`define TDQ_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// plain invariant on a boolean expression
`define TDQ_ASSERT_INV(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`else
`define TDQ_ASSERT(name, prop, msg)
`define TDQ_ASSERT_INV(name, expr, msg)
`endif
`endif

### rtl/tdq_pkg.sv
// types and constants of the transport delay queue
// no dependencies
package tdq_pkg;

    localparam int TDQ_QUEUE_DEPTH = 1024;
    localparam int TIME_W          = 48;
    localparam int DELAY_W         = 32;
    localparam int COEF_W          = 32;

    typedef enum logic
    {
        CMD_ARRIVE = 1'b0,
        CMD_FIRE   = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                      cmd;
        logic [TIME_W-1:0]         now_time;
        logic signed [COEF_W-1:0]  coef_value;
        logic signed [COEF_W-1:0]  coef_slope;
        logic signed [COEF_W-1:0]  coef_second;
        logic signed [COEF_W-1:0]  coef_third;
    } req_t;

    typedef struct packed
    {
        logic                      out_valid;
        logic signed [COEF_W-1:0]  out_value;
        logic signed [COEF_W-1:0]  out_slope;
        logic signed [COEF_W-1:0]  out_second;
        logic signed [COEF_W-1:0]  out_third;
        logic                      dropped;
        logic                      idle;
        logic [TIME_W-1:0]         due_time;
    } rsp_t;

    // one queue entry's coefficients, stored side by side
    typedef struct packed
    {
        logic signed [COEF_W-1:0]  value;
        logic signed [COEF_W-1:0]  slope;
        logic signed [COEF_W-1:0]  second;
        logic signed [COEF_W-1:0]  third;
    } coef_t;

    localparam int COEF_ENTRY_W = $bits(coef_t);

    // controller to datapath
    typedef struct packed
    {
        logic capture;
        logic exec;
        logic calc;
        logic commit;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic out_free;
    } dp_status_t;

endpackage

### rtl/tdq_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module tdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/tdq_ctrl.sv
// sequencer of the transport delay queue: one item through four steps
// depends on tdq_pkg
module tdq_ctrl
    import tdq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctl_cmd_t   cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_CALC,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;
    logic   accept;

    assign accept = in_valid && in_ready_reg;

    always_comb
    begin
        state_next    = state_reg;
        in_ready_next = in_ready_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next    = ST_EXEC;
                    in_ready_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_CALC;
            end
            ST_CALC:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next    = ST_IDLE;
                    in_ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next    = ST_IDLE;
                in_ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready    = in_ready_reg;
    assign cmd.capture = accept;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.calc    = (state_reg == ST_CALC);
    assign cmd.commit  = (state_reg == ST_COMMIT) && status.out_free;

endmodule

### rtl/tdq_dp.sv
// datapath of the transport delay queue: pointers, deadline, stores, output register
// depends on tdq_pkg, tdq_ram and the assertion header
`include "timestamped_transport_delay_queue_top_assert.svh"

module tdq_dp
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = TDQ_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DELAY_W-1:0] cfg_wdata,
    input  req_t               req,
    output rsp_t               rsp,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    input  ctl_cmd_t           cmd,
    output dp_status_t         status
);

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
        if (idx == LAST_IDX)
        begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    function automatic logic [TIME_W-1:0] not_before(input logic [TIME_W-1:0] t,
                                                    input logic [TIME_W-1:0] now);
        return (t < now) ? now : t;
    endfunction

    logic [DELAY_W-1:0] delay_reg;
    logic [ADDR_W-1:0]  head_reg;
    logic [ADDR_W-1:0]  head_next;
    logic [ADDR_W-1:0]  tail_reg;
    logic [ADDR_W-1:0]  tail_next;
    logic               empty_reg;
    logic               empty_next;
    logic [TIME_W-1:0]  due_reg;
    logic [TIME_W-1:0]  due_next;
    req_t               item_reg;
    logic [TIME_W-1:0]  dl_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic               rsp_valid_reg;

    logic               full;
    logic [ADDR_W-1:0]  head_adv;
    logic               ram_we;
    logic               ram_re;
    coef_t              coef_wdata;
    coef_t              coef_rdata;
    logic [TIME_W-1:0]  stamp_rdata;
    logic [TIME_W-1:0]  dl_base;
    logic [TIME_W:0]    dl_sum;

    assign full     = !empty_reg && (head_reg == tail_reg);
    assign head_adv = advance(head_reg);
    assign ram_we   = cmd.exec && (item_reg.cmd == CMD_ARRIVE) && !full;
    assign ram_re   = cmd.exec && (item_reg.cmd == CMD_FIRE);

    assign coef_wdata.value  = item_reg.coef_value;
    assign coef_wdata.slope  = item_reg.coef_slope;
    assign coef_wdata.second = item_reg.coef_second;
    assign coef_wdata.third  = item_reg.coef_third;

    tdq_ram #(
        .WIDTH (TIME_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_stamp_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (item_reg.now_time),
        .re    (ram_re),
        .raddr (head_adv),
        .rdata (stamp_rdata)
    );

    tdq_ram #(
        .WIDTH (COEF_ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (coef_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (coef_rdata)
    );

    // deadline of the arrival on arrive, of the next head on fire, saturated
    assign dl_base = (item_reg.cmd == CMD_FIRE) ? stamp_rdata : item_reg.now_time;
    assign dl_sum  = {1'b0, dl_base} + {{(TIME_W + 1 - DELAY_W){1'b0}}, delay_reg};

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        due_next   = due_reg;
        rsp_next   = '0;
        if (item_reg.cmd == CMD_ARRIVE)
        begin
            if (full)
            begin
                rsp_next.dropped = 1'b1;
            end
            else
            begin
                tail_next  = advance(tail_reg);
                due_next   = empty_reg ? dl_reg : not_before(due_reg, item_reg.now_time);
                empty_next = 1'b0;
            end
        end
        else if (!empty_reg)
        begin
            rsp_next.out_valid  = 1'b1;
            rsp_next.out_value  = coef_rdata.value;
            rsp_next.out_slope  = coef_rdata.slope;
            rsp_next.out_second = coef_rdata.second;
            rsp_next.out_third  = coef_rdata.third;
            head_next           = head_adv;
            if (head_adv == tail_reg)
            begin
                empty_next = 1'b1;
                due_next   = '0;
            end
            else
            begin
                due_next = not_before(dl_reg, item_reg.now_time);
            end
        end
        rsp_next.idle     = empty_next;
        rsp_next.due_time = empty_next ? '0 : due_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            due_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                delay_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                empty_reg     <= empty_next;
                due_reg       <= due_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.calc)
        begin
            dl_reg <= dl_sum[TIME_W] ? TIME_MAX : dl_sum[TIME_W-1:0];
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp             = rsp_reg;
    assign rsp_valid       = rsp_valid_reg;
    assign status.out_free = !rsp_valid_reg || rsp_ready;

    `TDQ_ASSERT_INV(a_empty_ptrs, !empty_reg || (head_reg == tail_reg), "empty queue with pointers apart")
    `TDQ_ASSERT(a_commit_free, cmd.commit |-> (!rsp_valid_reg || rsp_ready), "result overwrites a waiting item")
    `TDQ_ASSERT_INV(a_idle_due, !rsp_valid_reg || !rsp_reg.idle || (rsp_reg.due_time == '0), "idle result with nonzero due time")
    `TDQ_ASSERT_INV(a_drop_emit, !rsp_valid_reg || !(rsp_reg.dropped && rsp_reg.out_valid), "item both dropped and emitted")

endmodule

### rtl/timestamped_transport_delay_queue_top.sv
// Transport delay queue for four-coefficient Q16.16 samples. An item goes through four steps
// (capture, memory access, deadline add, commit), and the next item is accepted only once the
// result is committed, so the queue never takes a new item before it is through with the last.
// The memory's registered read and the 48-bit saturating add followed by the clamp compare
// are why these steps are separate. The commit waits only while the output register still
// holds the previous result and rsp_ready is low. Samples live in two RAMs of QUEUE_DEPTH
// entries (stamps and coefficients); no clearing pass runs after reset.
// top level: depends on tdq_pkg, tdq_ctrl, tdq_dp and tdq_ram
module timestamped_transport_delay_queue_top
    import tdq_pkg::*;
#(
    parameter int QUEUE_DEPTH = TDQ_QUEUE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [DELAY_W-1:0] cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  req_t               req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp
);

    ctl_cmd_t   cmd;
    dp_status_t status;

    tdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    tdq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

### bench/timestamped_transport_delay_queue_top_tb.sv
// self-checking bench for the transport delay queue: directed items, a fill to overflow with
// a partial drain, and random arrive/fire traffic under several delays and idling patterns
// depends on tdq_pkg and timestamped_transport_delay_queue_top
module timestamped_transport_delay_queue_top_tb;
    import tdq_pkg::*;

    localparam int IDX_W = $clog2(TDQ_QUEUE_DEPTH);
    localparam int LONG_HOLD = 80;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [DELAY_W-1:0] cfg_wdata = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    req_t               req = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    rsp_t               rsp;

    timestamped_transport_delay_queue_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #5 clk = ~clk;

    // shadow copy of the delay queue
    logic [DELAY_W-1:0] shadow_delay = '0;
    logic [TIME_W-1:0]  shadow_stamp [TDQ_QUEUE_DEPTH];
    coef_t              shadow_coef [TDQ_QUEUE_DEPTH];
    logic [IDX_W-1:0]   shadow_head = '0;
    logic [IDX_W-1:0]   shadow_tail = '0;
    logic [TIME_W-1:0]  shadow_due = '0;
    logic               shadow_empty = 1'b1;

    req_t pending_events [$];
    rsp_t expected_outcomes [$];

    int events_queued = 0;
    int events_accepted = 0;
    int arrivals_seen = 0;
    int fires_seen = 0;
    int samples_emitted = 0;
    int samples_dropped = 0;
    int mismatch_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;

    // stimulus-side bookkeeping, used only to shape traffic
    logic [TIME_W-1:0] stim_now = '0;
    int                stim_fill = 0;

    function automatic logic [TIME_W-1:0] stamp_deadline(logic [TIME_W-1:0] stamp);
        logic [TIME_W:0] sum;
        sum = {1'b0, stamp} + {{(TIME_W + 1 - DELAY_W){1'b0}}, shadow_delay};
        return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] no_earlier(logic [TIME_W-1:0] t,
                                                     logic [TIME_W-1:0] now);
        return (t < now) ? now : t;
    endfunction

    function automatic rsp_t predict_event(req_t ev);
        rsp_t r;
        r = '0;
        if (ev.cmd == CMD_ARRIVE)
        begin
            arrivals_seen++;
            if (!shadow_empty && shadow_head == shadow_tail)
            begin
                r.dropped = 1'b1;
                samples_dropped++;
            end
            else
            begin
                shadow_stamp[shadow_tail] = ev.now_time;
                shadow_coef[shadow_tail] = {ev.coef_value, ev.coef_slope,
                                            ev.coef_second, ev.coef_third};
                shadow_tail = shadow_tail + 1'b1;
                if (shadow_empty)
                    shadow_due = stamp_deadline(ev.now_time);
                else
                    shadow_due = no_earlier(shadow_due, ev.now_time);
                shadow_empty = 1'b0;
            end
        end
        else
        begin
            fires_seen++;
            if (!shadow_empty)
            begin
                r.out_valid  = 1'b1;
                r.out_value  = shadow_coef[shadow_head].value;
                r.out_slope  = shadow_coef[shadow_head].slope;
                r.out_second = shadow_coef[shadow_head].second;
                r.out_third  = shadow_coef[shadow_head].third;
                samples_emitted++;
                shadow_head = shadow_head + 1'b1;
                if (shadow_head == shadow_tail)
                begin
                    shadow_empty = 1'b1;
                    shadow_due = '0;
                end
                else
                    shadow_due = no_earlier(stamp_deadline(shadow_stamp[shadow_head]),
                                            ev.now_time);
            end
        end
        r.idle = shadow_empty;
        r.due_time = shadow_empty ? '0 : shadow_due;
        return r;
    endfunction

    function automatic void note_mismatch(string field, logic signed [63:0] want,
                                          logic signed [63:0] got);
        $error("%s: expected %0d, got %0d", field, want, got);
        mismatch_count++;
    endfunction

    function automatic void compare_outcome(rsp_t want, rsp_t got);
        if (got.out_valid !== want.out_valid)
            note_mismatch("out_valid", 64'(want.out_valid), 64'(got.out_valid));
        if (got.out_value !== want.out_value)
            note_mismatch("out_value", 64'(want.out_value), 64'(got.out_value));
        if (got.out_slope !== want.out_slope)
            note_mismatch("out_slope", 64'(want.out_slope), 64'(got.out_slope));
        if (got.out_second !== want.out_second)
            note_mismatch("out_second", 64'(want.out_second), 64'(got.out_second));
        if (got.out_third !== want.out_third)
            note_mismatch("out_third", 64'(want.out_third), 64'(got.out_third));
        if (got.dropped !== want.dropped)
            note_mismatch("dropped", 64'(want.dropped), 64'(got.dropped));
        if (got.idle !== want.idle)
            note_mismatch("idle", 64'(want.idle), 64'(got.idle));
        if (got.due_time !== want.due_time)
            note_mismatch("due_time", 64'(want.due_time), 64'(got.due_time));
    endfunction

    function automatic void enqueue_event(cmd_t op, logic [TIME_W-1:0] at,
                                          logic [COEF_W-1:0] v, logic [COEF_W-1:0] s,
                                          logic [COEF_W-1:0] s2, logic [COEF_W-1:0] s3);
        req_t ev;
        ev.cmd = op;
        ev.now_time = at;
        ev.coef_value = v;
        ev.coef_slope = s;
        ev.coef_second = s2;
        ev.coef_third = s3;
        pending_events.push_back(ev);
        events_queued++;
        if (op == CMD_ARRIVE && stim_fill < TDQ_QUEUE_DEPTH)
            stim_fill++;
        else if (op == CMD_FIRE && stim_fill > 0)
            stim_fill--;
    endfunction

    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly small forward steps, with jumps anywhere, near the top, and backwards
    function automatic void push_random(int count, int arrive_pct);
        logic [63:0] wide;
        cmd_t        op;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(15))
                0:
                begin
                    wide = {$urandom, $urandom};
                    stim_now = wide[TIME_W-1:0];
                end
                1: stim_now = '1 - TIME_W'($urandom_range(40));
                2: stim_now = stim_now - TIME_W'($urandom_range(200));
                default: stim_now = stim_now + TIME_W'($urandom_range(30));
            endcase
            op = CMD_FIRE;
            if ($urandom_range(99) < arrive_pct)
                op = CMD_ARRIVE;
            enqueue_event(op, stim_now, random_coef(), random_coef(), random_coef(),
                          random_coef());
        end
    endfunction

    task automatic wait_until_quiet();
        while (events_accepted != events_queued || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_delay(logic [DELAY_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_delay = value;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_outcomes.push_back(predict_event(req));
                events_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req <= pending_events.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus long hold-offs on request
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else if (hold_left != 0)
        begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (holds_served != hold_requests)
        begin
            rsp_ready <= 1'b0;
            hold_left <= LONG_HOLD;
            holds_served <= holds_served + 1;
        end
        else
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result item with nothing outstanding: due_time %0d", rsp.due_time);
                mismatch_count++;
            end
            else
                compare_outcome(expected_outcomes.pop_front(), rsp);
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // delay at its reset value of zero
        enqueue_event(CMD_FIRE, 48'd5, '1, '1, '1, '1);
        enqueue_event(CMD_ARRIVE, 48'd100, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      32'h7fff_ffff);
        // time runs backwards, deadline kept
        enqueue_event(CMD_ARRIVE, 48'd50, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000);
        // deadline raised to now
        enqueue_event(CMD_ARRIVE, 48'd200, '0, '0, '0, '0);
        enqueue_event(CMD_FIRE, 48'd10, '0, '0, '0, '0);
        enqueue_event(CMD_FIRE, 48'd300, '0, '0, '0, '0);
        enqueue_event(CMD_FIRE, 48'd0, '0, '0, '0, '0);
        enqueue_event(CMD_FIRE, 48'd0, '0, '0, '0, '0);
        enqueue_event(CMD_ARRIVE, '1, '1, '1, '1, '1);
        enqueue_event(CMD_FIRE, '1, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_0f0f,
                      32'hf0f0_f0f0);
        wait_until_quiet();

        // largest delay: deadlines saturate at the top of the time range
        write_delay('1);
        enqueue_event(CMD_ARRIVE, 48'hffff_ffff_fffa, 32'h0001_0000, 32'hffff_0000,
                      32'h0000_8000, 32'h5555_aaaa);
        enqueue_event(CMD_ARRIVE, 48'd0, 32'haaaa_5555, 32'h0000_0001, 32'hffff_fffe,
                      32'h7fff_0000);
        enqueue_event(CMD_FIRE, 48'd1, '0, '0, '0, '0);
        enqueue_event(CMD_ARRIVE, 48'h0000_ffff_0000, 32'h0000_0100, '0, '1, '0);
        enqueue_event(CMD_FIRE, '1, '0, '0, '0, '0);
        enqueue_event(CMD_FIRE, 48'h8000_0000_0000, '0, '0, '0, '0);
        wait_until_quiet();

        // no idling, one long receiver hold-off with the sender still offering
        write_delay($urandom_range(1, 1000));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        push_random(50, 55);
        // sender pauses until every result is back
        wait_until_quiet();
        push_random(50, 55);
        wait_until_quiet();

        write_delay('0);
        send_idle_pct = 63;
        recv_stall_pct = 0;
        push_random(80, 55);
        wait_until_quiet();

        write_delay('1);
        send_idle_pct = 0;
        recv_stall_pct = 63;
        push_random(80, 60);
        wait_until_quiet();

        // fill the queue to the brim across the tail wrap, overflow it, then drain part of it
        write_delay($urandom);
        send_idle_pct = 20;
        recv_stall_pct = 20;
        @(posedge clk);
        hold_requests <= hold_requests + 1;
        while (stim_fill < TDQ_QUEUE_DEPTH)
            push_random(1, 100);
        push_random(12, 100);
        push_random(200, 0);
        wait_until_quiet();

        write_delay(32'd1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        push_random(100, 50);
        wait_until_quiet();

        $display("covered %0d items: %0d arrivals, %0d fires, %0d samples emitted",
                 events_accepted, arrivals_seen, fires_seen, samples_emitted);
        $display("%0d arrivals dropped on a full queue, delays from zero to the maximum",
                 samples_dropped);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/tdq_pkg.sv
rtl/tdq_ram.sv
rtl/tdq_ctrl.sv
rtl/tdq_dp.sv
rtl/timestamped_transport_delay_queue_top.sv
bench/timestamped_transport_delay_queue_top_tb.sv
